/* design/ipv4cls_pkg.sv */
// Shared types and constants of the IPv4 port rule packet classifier.
`timescale 1ns / 1ps

package ipv4cls_pkg;

  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;

  typedef enum logic {
    ActWrite    = 1'b0,
    ActClassify = 1'b1
  } action_e;

  typedef enum logic {
    KindDst = 1'b0,
    KindSrc = 1'b1
  } rule_kind_e;

  typedef enum logic [1:0] {
    VerdictForward = 2'd0,
    VerdictKernel  = 2'd1,
    VerdictDrop    = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ReasonMatch   = 2'd0,
    ReasonNotIpv4 = 2'd1,
    ReasonNotL4   = 2'd2,
    ReasonNoMatch = 2'd3
  } reason_e;

  typedef enum logic [1:0] {
    CfgRulesInUse = 2'd0,
    CfgKernelEn   = 2'd1
  } cfg_index_e;

  typedef struct packed {
    rule_kind_e  kind;
    logic [31:0] addr;
    logic [15:0] port;
  } rule_t;

  // word that walks along the cell chain
  typedef struct packed {
    action_e     act;
    logic [5:0]  idx;
    rule_t       rule;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    reason_e     pre_reason;
    logic        hit;
  } word_t;

endpackage

/* design/ipv4cls_cell.sv */
// One rule slot of the classifier chain: holds a rule and passes the word on.
`timescale 1ns / 1ps

module ipv4cls_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ipv4cls_pkg::word_t  word_i,
  input  logic                wr_sel_i,
  input  logic                match_en_i,
  output logic                valid_o,
  output ipv4cls_pkg::word_t  word_o
);
  import ipv4cls_pkg::*;

  rule_t rule_q;
  logic  valid_q;
  word_t word_q, word_d;
  logic  match;

  always_comb begin
    if (rule_q.kind == KindDst) begin
      match = (rule_q.addr == word_i.da) && (rule_q.port == word_i.dp);
    end else begin
      match = (rule_q.addr == word_i.sa) && (rule_q.port == word_i.sp);
    end
  end

  always_comb begin
    word_d = word_i;
    word_d.hit = word_i.hit | (valid_i && (word_i.act == ActClassify) &&
                               (word_i.pre_reason == ReasonNoMatch) &&
                               match_en_i && match);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (valid_i && (word_i.act == ActWrite) && wr_sel_i) begin
      rule_q <= word_i.rule;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

/* design/ipv4_port_rule_packet_classifier.sv */
// Top level of the IPv4 port rule packet classifier.
`timescale 1ns / 1ps
// Usage:
//   A word is taken on every clock edge with start_i high and busy_o low;
//   busy_o stays low, so a word can be issued every cycle. action_i selects
//   a rule write (rule_index_i, rule_kind_i, rule_addr_i, rule_portnum_i)
//   or a packet classify (ether_kind_i, ip_proto_i and the address/port
//   fields). Words walk a chain of RULE_SLOTS cells, one cell per cycle,
//   each cell holding one rule; a write lands in its slot as it passes, and
//   a later classify always sees it because words never overtake.
//   Result: a classify gives verdict_o/reason_o with valid_o high for one
//   cycle, after all cells and the result register. Writes give no result.
//   Throughput: one word per cycle, set by the one-cell-per-cycle chain.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_wdata_i;
//   cfg_ready_o is always high. Change config only while no classify is
//   in the chain.
//   Reset clears the chain, the result strobe and both config registers;
//   rule slots read undefined until written. The receiver cannot stall:
//   each result is shown for exactly one cycle.

module ipv4_port_rule_packet_classifier #(
  parameter int unsigned RULE_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [5:0]  rule_index_i,
  input  logic        rule_kind_i,
  input  logic [31:0] rule_addr_i,
  input  logic [15:0] rule_portnum_i,
  input  logic [15:0] ether_kind_i,
  input  logic [7:0]  ip_proto_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_portnum_i,
  input  logic [15:0] dst_portnum_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        valid_o,
  output logic [1:0]  verdict_o,
  output logic [1:0]  reason_o
);
  import ipv4cls_pkg::*;

  logic [6:0] rules_in_use_q;
  logic       kernel_en_q;

  logic  valid_c [RULE_SLOTS+1];
  word_t word_c  [RULE_SLOTS+1];

  logic     res_valid_q;
  verdict_e verdict_q, verdict_d;
  reason_e  reason_q, reason_d;
  verdict_e unmatched;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_in_use_q <= '0;
      kernel_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgRulesInUse: rules_in_use_q <= cfg_wdata_i;
        CfgKernelEn:   kernel_en_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // entry word
  always_comb begin
    valid_c[0]           = start_i && !busy_o;
    word_c[0].act        = action_e'(action_i);
    word_c[0].idx        = rule_index_i;
    word_c[0].rule.kind  = rule_kind_e'(rule_kind_i);
    word_c[0].rule.addr  = rule_addr_i;
    word_c[0].rule.port  = rule_portnum_i;
    word_c[0].sa         = src_addr_i;
    word_c[0].da         = dst_addr_i;
    word_c[0].sp         = src_portnum_i;
    word_c[0].dp         = dst_portnum_i;
    word_c[0].hit        = 1'b0;
    if (ether_kind_i != EtherIpv4) begin
      word_c[0].pre_reason = ReasonNotIpv4;
    end else if ((ip_proto_i != ProtoTcp) && (ip_proto_i != ProtoUdp)) begin
      word_c[0].pre_reason = ReasonNotL4;
    end else begin
      word_c[0].pre_reason = ReasonNoMatch;
    end
  end

  for (genvar k = 0; k < RULE_SLOTS; k++) begin : g_cell
    logic wr_sel;
    logic match_en;

    assign wr_sel   = (32'(word_c[k].idx) == 32'(k));
    assign match_en = (32'(rules_in_use_q) > 32'(k));

    ipv4cls_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (valid_c[k]),
      .word_i     (word_c[k]),
      .wr_sel_i   (wr_sel),
      .match_en_i (match_en),
      .valid_o    (valid_c[k+1]),
      .word_o     (word_c[k+1])
    );
  end

  always_comb begin
    unmatched = kernel_en_q ? VerdictKernel : VerdictDrop;
    if (word_c[RULE_SLOTS].pre_reason != ReasonNoMatch) begin
      verdict_d = unmatched;
      reason_d  = word_c[RULE_SLOTS].pre_reason;
    end else if (word_c[RULE_SLOTS].hit) begin
      verdict_d = VerdictForward;
      reason_d  = ReasonMatch;
    end else begin
      verdict_d = unmatched;
      reason_d  = ReasonNoMatch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= valid_c[RULE_SLOTS] && (word_c[RULE_SLOTS].act == ActClassify);
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    reason_q  <= reason_d;
  end

  assign valid_o   = res_valid_q;
  assign verdict_o = verdict_q;
  assign reason_o  = reason_q;

endmodule

/* design/ipv4cls_chk.sv */
// Port-level checker for the classifier, bound to the top level.
`timescale 1ns / 1ps

module ipv4cls_chk #(
  parameter int unsigned RULE_SLOTS = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        action_i,
  input logic [15:0] ether_kind_i,
  input logic        valid_o,
  input logic [1:0]  verdict_o,
  input logic [1:0]  reason_o
);
  import ipv4cls_pkg::*;

  localparam int unsigned Lat = RULE_SLOTS + 1;

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (verdict_o == VerdictForward || verdict_o == VerdictKernel ||
                 verdict_o == VerdictDrop))
    else $error("verdict code out of range");

  a_forward_iff_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((verdict_o == VerdictForward) == (reason_o == ReasonMatch)))
    else $error("forward verdict and match reason disagree");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o && (action_i == ActClassify), Lat))
    else $error("result without a classify word taken");

  a_not_ipv4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((reason_o == ReasonNotIpv4) == ($past(ether_kind_i, Lat) != EtherIpv4)))
    else $error("not-IPv4 reason mismatch");

endmodule

bind ipv4_port_rule_packet_classifier ipv4cls_chk #(.RULE_SLOTS(RULE_SLOTS)) u_chk (.*);
